// ===== src/lds_pkg.sv =====
`default_nettype none

package lds_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TRACK_BITS  = 16;
  localparam int TAG_BITS    = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = TAG_BITS + TRACK_BITS;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_PICK = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_GRANTED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       add_wr;
    logic       scan_start;
    logic       scan_rd;
    logic       pick;
    logic       shift_rd;
    logic       finish;
    logic       out_load;
    logic [1:0] code;
  } lds_cmd_t;

  typedef struct packed {
    logic kind;
    logic empty;
    logic full;
    logic idx_last;
    logic no_shift;
    logic out_free;
  } lds_sts_t;

endpackage

`default_nettype wire

// ===== src/lds_req_if.sv =====
`default_nettype none

interface lds_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [lds_pkg::TAG_BITS-1:0]   request_tag;
  logic [lds_pkg::TRACK_BITS-1:0] request_track;
  logic [lds_pkg::TRACK_BITS-1:0] head_track;

  modport source (
    output valid, req_type, request_tag, request_track, head_track,
    input  ready
  );

  modport sink (
    input  valid, req_type, request_tag, request_track, head_track,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/lds_rsp_if.sv =====
`default_nettype none

interface lds_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [lds_pkg::TAG_BITS-1:0]   grant_tag;
  logic [lds_pkg::TRACK_BITS-1:0] grant_track;
  logic                          sweep_up;
  logic [lds_pkg::CNT_W-1:0]      pending_count;

  modport source (
    output valid, status, grant_tag, grant_track, sweep_up, pending_count,
    input  ready
  );

  modport sink (
    input  valid, status, grant_tag, grant_track, sweep_up, pending_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/lds_ctrl.sv =====
`default_nettype none

module lds_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lds_pkg::lds_sts_t sts_i,
  output lds_pkg::lds_cmd_t      cmd_o
);
  import lds_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_SCAN      = 4'd2;
  localparam logic [3:0] S_SETTLE    = 4'd3;
  localparam logic [3:0] S_PICK      = 4'd4;
  localparam logic [3:0] S_SHIFT     = 4'd5;
  localparam logic [3:0] S_SHIFT_END = 4'd6;
  localparam logic [3:0] S_FINISH    = 4'd7;
  localparam logic [3:0] S_RESULT    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] code_q, code_d;

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.code = code_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.kind == REQ_ADD) begin
          if (sts_i.full) begin
            code_d = ST_FULL;
          end else begin
            cmd_o.add_wr = 1'b1;
            code_d       = ST_ADDED;
          end
          state_d = S_RESULT;
        end else if (sts_i.empty) begin
          code_d  = ST_EMPTY;
          state_d = S_RESULT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SETTLE;
        end
      end
      S_SETTLE: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = sts_i.no_shift ? S_FINISH : S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SHIFT_END;
        end
      end
      S_SHIFT_END: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        code_d       = ST_GRANTED;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_ADDED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  // commands only ever fire from their own states
  a_scan_not_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.scan_rd && cmd_o.shift_rd))
    else $error("scan and shift reads in the same cycle");

  a_pick_after_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pick |-> $past(state_q) == S_SETTLE)
    else $error("pick without completed scan");

  a_load_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> in_ready_o)
    else $error("not idle after result load");

endmodule

`default_nettype wire

// ===== src/lds_dp.sv =====
`default_nettype none

module lds_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lds_pkg::lds_cmd_t             cmd_i,
  output lds_pkg::lds_sts_t                  sts_o,
  input  wire logic                          req_type_i,
  input  wire logic [lds_pkg::TAG_BITS-1:0]   request_tag_i,
  input  wire logic [lds_pkg::TRACK_BITS-1:0] request_track_i,
  input  wire logic [lds_pkg::TRACK_BITS-1:0] head_track_i,
  input  wire logic                          rsp_ready_i,
  output logic                               rsp_valid_o,
  output logic [1:0]                         status_o,
  output logic [lds_pkg::TAG_BITS-1:0]        grant_tag_o,
  output logic [lds_pkg::TRACK_BITS-1:0]      grant_track_o,
  output logic                               sweep_up_o,
  output logic [lds_pkg::CNT_W-1:0]           pending_count_o
);
  import lds_pkg::*;

  logic [ENTRY_W-1:0]    mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]    rdata_q;
  logic [IDX_W-1:0]      rd_idx_q;

  logic                  kind_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [TRACK_BITS-1:0] trk_q;
  logic [TRACK_BITS-1:0] head_q;

  logic [CNT_W-1:0]      count_q;
  logic                  dir_q;
  logic [CNT_W-1:0]      idx_q;
  logic                  scan_v_q;
  logic                  shift_v_q;

  logic                  up_found_q, dn_found_q;
  logic [TRACK_BITS-1:0] up_dist_q, dn_dist_q;
  logic [IDX_W-1:0]      up_idx_q, dn_idx_q;
  logic [TAG_BITS-1:0]   up_tag_q, dn_tag_q;
  logic [TRACK_BITS-1:0] up_trk_q, dn_trk_q;

  logic [TAG_BITS-1:0]   g_tag_q;
  logic [TRACK_BITS-1:0] g_trk_q;

  logic                  out_valid_q;
  logic [1:0]            out_status_q;
  logic [TAG_BITS-1:0]   out_tag_q;
  logic [TRACK_BITS-1:0] out_trk_q;
  logic                  out_dir_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic [TRACK_BITS-1:0] rd_trk;
  logic [TAG_BITS-1:0]   rd_tag;
  logic [TRACK_BITS-1:0] d_up, d_dn;
  logic                  upd_up, upd_dn;
  logic                  new_dir;
  logic [IDX_W-1:0]      sel_idx;
  logic [CNT_W-1:0]      sel_next;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_wa;
  logic [ENTRY_W-1:0]    mem_wd;
  logic                  out_free;

  assign rd_trk = rdata_q[TRACK_BITS-1:0];
  assign rd_tag = rdata_q[TRACK_BITS +: TAG_BITS];
  assign d_up   = rd_trk - head_q;
  assign d_dn   = head_q - rd_trk;
  assign upd_up = scan_v_q && (rd_trk >= head_q) && (!up_found_q || (d_up < up_dist_q));
  assign upd_dn = scan_v_q && (rd_trk <= head_q) && (!dn_found_q || (d_dn < dn_dist_q));

  // LOOK reversal: keep direction while something lies ahead
  assign new_dir  = dir_q ? up_found_q : !dn_found_q;
  assign sel_idx  = new_dir ? up_idx_q : dn_idx_q;
  assign sel_next = CNT_W'(sel_idx) + CNT_W'(1);

  assign mem_we = cmd_i.add_wr || shift_v_q;
  assign mem_wa = shift_v_q ? (rd_idx_q - IDX_W'(1)) : count_q[IDX_W-1:0];
  assign mem_wd = shift_v_q ? rdata_q : {tag_q, trk_q};
  assign mem_re = cmd_i.scan_rd || cmd_i.shift_rd;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    sts_o          = '0;
    sts_o.kind     = kind_q;
    sts_o.empty    = (count_q == '0);
    sts_o.full     = (count_q == CNT_W'(QUEUE_DEPTH));
    sts_o.idx_last = (idx_q == (count_q - CNT_W'(1)));
    sts_o.no_shift = (sel_next >= count_q);
    sts_o.out_free = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q  <= mem[idx_q[IDX_W-1:0]];
      rd_idx_q <= idx_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dir_q       <= 1'b1;
      idx_q       <= '0;
      scan_v_q    <= 1'b0;
      shift_v_q   <= 1'b0;
      up_found_q  <= 1'b0;
      dn_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_v_q  <= cmd_i.scan_rd;
      shift_v_q <= cmd_i.shift_rd;
      if (cmd_i.add_wr) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.finish) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        idx_q      <= '0;
        up_found_q <= 1'b0;
        dn_found_q <= 1'b0;
      end else if (cmd_i.pick) begin
        idx_q <= sel_next;
        dir_q <= new_dir;
      end else if (mem_re) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (upd_up) begin
        up_found_q <= 1'b1;
      end
      if (upd_dn) begin
        dn_found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= req_type_i;
      tag_q  <= request_tag_i;
      trk_q  <= request_track_i;
      head_q <= head_track_i;
    end
    if (upd_up) begin
      up_dist_q <= d_up;
      up_idx_q  <= rd_idx_q;
      up_tag_q  <= rd_tag;
      up_trk_q  <= rd_trk;
    end
    if (upd_dn) begin
      dn_dist_q <= d_dn;
      dn_idx_q  <= rd_idx_q;
      dn_tag_q  <= rd_tag;
      dn_trk_q  <= rd_trk;
    end
    if (cmd_i.pick) begin
      g_tag_q <= new_dir ? up_tag_q : dn_tag_q;
      g_trk_q <= new_dir ? up_trk_q : dn_trk_q;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.code;
      out_tag_q    <= (cmd_i.code == ST_GRANTED) ? g_tag_q : '0;
      out_trk_q    <= (cmd_i.code == ST_GRANTED) ? g_trk_q : '0;
      out_dir_q    <= dir_q;
      out_cnt_q    <= count_q;
    end
  end

  assign rsp_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign grant_tag_o     = out_tag_q;
  assign grant_track_o   = out_trk_q;
  assign sweep_up_o      = out_dir_q;
  assign pending_count_o = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond table depth");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_v_q |-> (rd_idx_q != '0) && (CNT_W'(rd_idx_q) < count_q))
    else $error("compaction write outside table");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result overwritten before taken");

  a_pick_has_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> (up_found_q || dn_found_q))
    else $error("pick with no candidate");

endmodule

`default_nettype wire

// ===== src/look_disk_scheduler.sv =====
// Steps: an add, or a pick on an empty table, goes from decode to the result state. A pick over
// a nonempty table runs a scan pass, a settle and a pick state, a compaction pass when entries sit
// behind the granted one, then a finish state (one table read per cycle: one pass for the scan,
// one for the compaction). One transaction at a time: input ready only while idle.
// Reset: empty table, sweep upward, no result pending; table contents stay undefined
// and need no clearing pass.
`default_nettype none

module look_disk_scheduler (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lds_req_if.sink   req_i,
  lds_rsp_if.source rsp_o
);
  import lds_pkg::*;

  lds_cmd_t cmd;
  lds_sts_t sts;
  logic     in_ready;

  lds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lds_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_i.req_type),
    .request_tag_i   (req_i.request_tag),
    .request_track_i (req_i.request_track),
    .head_track_i    (req_i.head_track),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .status_o        (rsp_o.status),
    .grant_tag_o     (rsp_o.grant_tag),
    .grant_track_o   (rsp_o.grant_track),
    .sweep_up_o      (rsp_o.sweep_up),
    .pending_count_o (rsp_o.pending_count)
  );

  assign req_i.ready = in_ready;

endmodule

`default_nettype wire
